### hw/rtl/clle_pkg.sv
package clle_pkg;

	// action codes carried on the input tuser
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_ERASE  = 2'd1,
		ACT_GET    = 2'd2,
		ACT_FIND   = 2'd3
	} action_t;

	// status codes carried on the output tuser
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// commands to the slot occupancy map
	typedef struct packed {
		logic take; // claim the current lowest free slot
		logic drop; // free the slot given alongside
	} used_cmd_t;

	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 48;
	localparam int unsigned POS_W      = 7;
	localparam int unsigned PORT_VAL_W = 32;
	localparam int unsigned FOUND_W    = 6;
	localparam int unsigned COUNT_W    = 7;

endpackage

### hw/rtl/cursor_linked_list_engine_unit.sv
// Ordered list engine: doubly linked slots in one synchronous memory, one word in flight.
// Per word: get walks to the position, index-of walks until a match or the tail, erase walks
// and then makes up to two read-modify-write link repairs, and insert first waits for the
// background lowest-free-slot search that follows an earlier insert, then walks unless at the
// head and makes up to two link repairs. The link walk, one memory read per cycle, sets the rate.
// Reset: asynchronous, clears used flags, head and count; slot memory needs no clearing.
module cursor_linked_list_engine_unit #(
	parameter int unsigned CAPACITY    = 64,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input words
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [clle_pkg::IN_DATA_W-1:0]   s_tdata,  // position[6:0], value[38:7], pad
	input  logic [1:0]                       s_tuser,  // action[1:0]
	// result words
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [clle_pkg::OUT_DATA_W-1:0]  m_tdata,  // read_value[31:0], found_index[37:32],
	                                                   // element_count[44:38], is_empty[45],
	                                                   // is_full[46], pad
	output logic [1:0]                       m_tuser   // status[1:0]
);
	import clle_pkg::*;

	// link and count width holds CAPACITY itself, which marks "no slot"
	localparam int unsigned LW   = $clog2(CAPACITY + 1);
	localparam int unsigned SW   = $clog2(CAPACITY);
	localparam int unsigned CMPW = (LW > POS_W) ? LW : POS_W;
	localparam int unsigned VW   = VALUE_WIDTH;
	localparam int unsigned EW   = VW + 2 * LW;
	localparam logic [LW-1:0] NONE = LW'(CAPACITY);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FREE  = 8'b0000_0010,
		S_START = 8'b0000_0100,
		S_STEP  = 8'b0000_1000,
		S_NEW   = 8'b0001_0000,
		S_FIXRD = 8'b0010_0000,
		S_FIXWR = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t           state_q;
	action_t          act_q;
	logic [POS_W-1:0] pos_q;
	logic [VW-1:0]    key_q;
	logic [LW-1:0]    count_q;
	logic [LW-1:0]    head_q;
	logic [LW-1:0]    cur_q;
	logic [CMPW-1:0]  idx_q;
	logic [CMPW-1:0]  tgt_q;
	logic [LW-1:0]    neo_q;
	logic [LW-1:0]    new_next_q;
	logic [LW-1:0]    new_prev_q;
	logic [1:0]       fix_v_q;
	logic [LW-1:0]    fix_slot_q [2];
	logic             fix_nxt_q  [2];  // 1: repair next link, 0: repair prev link
	logic [LW-1:0]    fix_link_q [2];
	status_t          status_q;
	logic [VW-1:0]    rval_q;
	logic [FOUND_W-1:0] found_q;

	// output register
	logic               out_valid_q;
	status_t            o_status_q;
	logic [PORT_VAL_W-1:0] o_rval_q;
	logic [FOUND_W-1:0] o_found_q;
	logic [COUNT_W-1:0] o_count_q;
	logic               o_empty_q;
	logic               o_full_q;

	// memory port
	logic          mem_we;
	logic [SW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [SW-1:0] mem_raddr;
	logic [EW-1:0] mem_rdata;
	logic [VW-1:0] rd_val;
	logic [LW-1:0] rd_next;
	logic [LW-1:0] rd_prev;

	// occupancy map
	used_cmd_t     ucmd;
	logic          free_valid;
	logic [SW-1:0] free_slot;

	// input fields
	action_t          in_act;
	logic [POS_W-1:0] in_pos;
	logic [CMPW-1:0]  in_posx;
	logic [CMPW-1:0]  posx;
	logic [CMPW-1:0]  cntx;
	logic             pos_lt_cnt;
	logic             pos1_lt_cnt;
	logic             fsel;
	logic             arrive;
	logic             accept;
	logic             out_load;
	logic [LW-1:0]    free_link;
	logic [LW-1:0]    er_next;

	// true while another element follows index i in a list of n
	function automatic logic pos1_lt_cnt_find(input logic [CMPW-1:0] i,
	                                          input logic [CMPW-1:0] n);
		return ((CMPW + 1)'(i) + 1'b1) < (CMPW + 1)'(n);
	endfunction

	assign in_act  = action_t'(s_tuser);
	assign in_pos  = s_tdata[POS_W-1:0];
	assign in_posx = CMPW'(in_pos);
	assign posx    = CMPW'(pos_q);
	assign cntx    = CMPW'(count_q);

	assign pos_lt_cnt  = posx < cntx;
	assign pos1_lt_cnt = ((CMPW + 1)'(posx) + 1'b1) < (CMPW + 1)'(cntx);

	assign rd_prev = mem_rdata[LW-1:0];
	assign rd_next = mem_rdata[2*LW-1:LW];
	assign rd_val  = mem_rdata[EW-1:2*LW];

	// repair entry 0 first, then entry 1
	assign fsel      = ~fix_v_q[0];
	assign free_link = LW'(free_slot);
	// successor of the erased element, none at the tail
	assign er_next   = pos1_lt_cnt ? rd_next : NONE;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign arrive   = (state_q == S_STEP) && (act_q != ACT_FIND) && (idx_q == tgt_q);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);

	assign ucmd = '{take: (state_q == S_FREE) && free_valid,
	                drop: arrive && (act_q == ACT_ERASE)};

	// memory addressing: walk reads follow the link just read
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = SW'(neo_q);
		mem_wdata = {key_q, new_next_q, new_prev_q};
		mem_raddr = SW'(head_q);
		if (state_q == S_NEW) begin
			mem_we = 1'b1;
		end
		if (state_q == S_FIXWR) begin
			mem_we    = 1'b1;
			mem_waddr = SW'(fix_slot_q[fsel]);
			mem_wdata = fix_nxt_q[fsel] ? {rd_val, fix_link_q[fsel], rd_prev}
			                            : {rd_val, rd_next, fix_link_q[fsel]};
		end
		if (state_q == S_STEP) begin
			mem_raddr = SW'(rd_next);
		end
		if (state_q == S_FIXRD) begin
			mem_raddr = SW'(fix_slot_q[fsel]);
		end
	end

	clle_slot_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (EW),
		.AW    (SW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	clle_used_map #(
		.CAPACITY (CAPACITY),
		.SW       (SW)
	) u_used (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ucmd),
		.drop_slot  (SW'(cur_q)),
		.free_valid (free_valid),
		.free_slot  (free_slot)
	);

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= in_act;
			pos_q   <= in_pos;
			key_q   <= VW'(s_tdata[POS_W +: PORT_VAL_W]);
			rval_q  <= '0;
			found_q <= '0;
			tgt_q   <= in_posx;
		end
		if (state_q == S_FREE && free_valid) begin
			neo_q <= free_link;
			if (pos_q == '0) begin
				// new head: old head gets the new slot as its predecessor
				new_next_q    <= (count_q != '0) ? head_q : NONE;
				new_prev_q    <= NONE;
				fix_slot_q[0] <= head_q;
				fix_nxt_q[0]  <= 1'b0;
				fix_link_q[0] <= free_link;
			end else begin
				tgt_q <= posx - 1'b1;
			end
		end
		if (state_q == S_START) begin
			cur_q <= head_q;
			idx_q <= '0;
		end
		if (state_q == S_STEP) begin
			if (act_q == ACT_FIND) begin
				if (rd_val == key_q) begin
					found_q <= FOUND_W'(idx_q);
				end
			end else if (arrive) begin
				unique case (act_q)
					ACT_INSERT: begin
						// link new slot between cursor and its successor
						new_next_q    <= pos_lt_cnt ? rd_next : NONE;
						new_prev_q    <= cur_q;
						fix_slot_q[0] <= cur_q;
						fix_nxt_q[0]  <= 1'b1;
						fix_link_q[0] <= neo_q;
						fix_slot_q[1] <= rd_next;
						fix_nxt_q[1]  <= 1'b0;
						fix_link_q[1] <= neo_q;
					end
					ACT_ERASE: begin
						// bypass the cursor slot from both neighbors
						fix_slot_q[0] <= rd_prev;
						fix_nxt_q[0]  <= 1'b1;
						fix_link_q[0] <= er_next;
						fix_slot_q[1] <= rd_next;
						fix_nxt_q[1]  <= 1'b0;
						fix_link_q[1] <= (pos_q == '0) ? NONE : rd_prev;
					end
					ACT_GET: begin
						rval_q <= rd_val;
					end
					default: begin
					end
				endcase
			end
			if (!arrive) begin
				cur_q <= rd_next;
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// control: state, list head, count, pending repairs, status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= NONE;
			count_q  <= '0;
			fix_v_q  <= '0;
			status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_OK;
						fix_v_q  <= '0;
						unique case (in_act)
							ACT_INSERT: begin
								if (in_posx > cntx) begin
									status_q <= ST_RANGE;
									state_q  <= S_DONE;
								end else if (count_q == LW'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_FREE;
								end
							end
							ACT_ERASE, ACT_GET: begin
								if (in_posx >= cntx) begin
									status_q <= ST_RANGE;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_START;
								end
							end
							ACT_FIND: begin
								if (count_q == '0) begin
									status_q <= ST_NOT_FOUND;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_START;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_FREE: begin
					// hold until the lowest free slot is known
					if (free_valid) begin
						if (pos_q == '0) begin
							fix_v_q <= {1'b0, count_q != '0};
							head_q  <= free_link;
							count_q <= count_q + 1'b1;
							state_q <= S_NEW;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (act_q == ACT_FIND) begin
						if (rd_val == key_q) begin
							state_q <= S_DONE;
						end else if (!pos1_lt_cnt_find(idx_q, cntx)) begin
							status_q <= ST_NOT_FOUND;
							state_q  <= S_DONE;
						end
					end else if (arrive) begin
						unique case (act_q)
							ACT_INSERT: begin
								fix_v_q <= {pos_lt_cnt, 1'b1};
								count_q <= count_q + 1'b1;
								state_q <= S_NEW;
							end
							ACT_ERASE: begin
								if (pos_q == '0) begin
									head_q <= er_next;
								end
								fix_v_q <= {pos1_lt_cnt, pos_q != '0};
								count_q <= count_q - 1'b1;
								if (pos1_lt_cnt || pos_q != '0) begin
									state_q <= S_FIXRD;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_NEW: begin
					state_q <= (fix_v_q != '0) ? S_FIXRD : S_DONE;
				end
				S_FIXRD: begin
					state_q <= S_FIXWR;
				end
				S_FIXWR: begin
					fix_v_q[fsel] <= 1'b0;
					state_q <= (fix_v_q[0] && fix_v_q[1]) ? S_FIXRD : S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result word holds here while the next word is taken and worked on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_status_q <= status_q;
			o_rval_q   <= PORT_VAL_W'(rval_q);
			o_found_q  <= found_q;
			o_count_q  <= COUNT_W'(count_q);
			o_empty_q  <= (count_q == '0);
			o_full_q   <= (count_q == LW'(CAPACITY));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = o_status_q;
	assign m_tdata  = {1'b0, o_full_q, o_empty_q, o_count_q, o_found_q, o_rval_q};

endmodule

### hw/rtl/clle_slot_mem.sv
module clle_slot_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 46,
	parameter int unsigned AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/clle_used_map.sv
module clle_used_map #(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned SW       = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  clle_pkg::used_cmd_t cmd,
	input  logic [SW-1:0]       drop_slot,
	output logic                free_valid,
	output logic [SW-1:0]       free_slot
);
	import clle_pkg::*;

	localparam logic [SW-1:0] LAST = SW'(CAPACITY - 1);

	logic [CAPACITY-1:0] used_q;
	logic [SW-1:0]       free_q;
	logic                free_v_q;
	logic [SW-1:0]       scan_q;
	logic                scan_on_q;

	// Keep the lowest free slot ready; after a take, search upward one flag a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			free_q    <= '0;
			free_v_q  <= 1'b1;
			scan_q    <= '0;
			scan_on_q <= 1'b0;
		end else begin
			if (scan_on_q && !free_v_q) begin
				if (!used_q[scan_q]) begin
					free_q    <= scan_q;
					free_v_q  <= 1'b1;
					scan_on_q <= 1'b0;
				end else if (scan_q == LAST) begin
					scan_on_q <= 1'b0;
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			if (cmd.take) begin
				used_q[free_q] <= 1'b1;
				free_v_q       <= 1'b0;
				if (free_q == LAST) begin
					scan_on_q <= 1'b0;
				end else begin
					scan_q    <= free_q + 1'b1;
					scan_on_q <= 1'b1;
				end
			end
			if (cmd.drop) begin
				used_q[drop_slot] <= 1'b0;
				if (free_v_q) begin
					if (drop_slot < free_q) begin
						free_q <= drop_slot;
					end
				end else if (!scan_on_q || drop_slot <= scan_q) begin
					free_q    <= drop_slot;
					free_v_q  <= 1'b1;
					scan_on_q <= 1'b0;
				end
			end
		end
	end

	assign free_valid = free_v_q;
	assign free_slot  = free_q;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import clle_pkg::*;

	localparam int unsigned SLOTS      = 64;
	localparam int unsigned CYCLE_CAP  = 1000000;
	localparam int unsigned TAIL_WAIT  = 200;

	typedef struct {
		status_t     status;
		logic [31:0] read_value;
		logic [5:0]  found_index;
		logic [6:0]  element_count;
		logic        is_empty;
		logic        is_full;
	} list_result_t;

	// Shadow of the list in order, head first, plus the results still owed by the block.
	class list_scoreboard;
		logic [31:0]  list_values[$];
		list_result_t due_results[$];
		int unsigned  errors;

		function int unsigned occupancy();
			return list_values.size();
		endfunction

		function int unsigned due_count();
			return due_results.size();
		endfunction

		function logic [31:0] value_at(int unsigned idx);
			return list_values[idx];
		endfunction

		// Apply one accepted input word to the shadow list and queue its result.
		function void note_word(action_t act, logic [6:0] pos, logic [31:0] val);
			list_result_t r;
			int unsigned  size;
			size = list_values.size();
			r.status = ST_OK;
			r.read_value = '0;
			r.found_index = '0;
			case (act)
				ACT_INSERT: begin
					// range check wins over the full check
					if (pos > size)
						r.status = ST_RANGE;
					else if (size >= SLOTS)
						r.status = ST_FULL;
					else
						list_values.insert(pos, val);
				end
				ACT_ERASE: begin
					if (pos >= size)
						r.status = ST_RANGE;
					else
						list_values.delete(pos);
				end
				ACT_GET: begin
					if (pos >= size)
						r.status = ST_RANGE;
					else
						r.read_value = list_values[pos];
				end
				default: begin
					// first match wins; position is ignored
					r.status = ST_NOT_FOUND;
					for (int i = 0; i < size; i++) begin
						if (list_values[i] == val) begin
							r.status = ST_OK;
							r.found_index = 6'(i);
							break;
						end
					end
				end
			endcase
			r.element_count = 7'(list_values.size());
			r.is_empty = (list_values.size() == 0);
			r.is_full = (list_values.size() >= SLOTS);
			due_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Check one accepted result word against the oldest outstanding result.
		function void check_word(logic [1:0] st, logic [OUT_DATA_W-1:0] d);
			list_result_t e;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result word, expected none, got status %0h data %0h",
					$time, st, d);
				errors++;
				return;
			end
			e = due_results.pop_front();
			compare_field("status", 32'(e.status), 32'(st));
			compare_field("read_value", e.read_value, d[31:0]);
			compare_field("found_index", 32'(e.found_index), 32'(d[37:32]));
			compare_field("element_count", 32'(e.element_count), 32'(d[44:38]));
			compare_field("is_empty", 32'(e.is_empty), 32'(d[45]));
			compare_field("is_full", 32'(e.is_full), 32'(d[46]));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	list_scoreboard board = new();
	bit             send_quiet = 1'b0;
	bit             take_quiet = 1'b0;
	int unsigned    cycles = 0;

	always #5 clk = ~clk;

	cursor_linked_list_engine_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	function automatic int unsigned idle_cycles(bit quiet);
		return quiet ? 0 : $urandom_range(0, 19);
	endfunction

	// Present one word, hold it until taken, then idle for a random gap.
	task automatic send_word(action_t act, logic [6:0] pos, logic [31:0] val);
		int unsigned gap;
		s_tuser <= act;
		s_tdata <= {1'b0, val, pos};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_word(act, pos, val);
		gap = idle_cycles(send_quiet);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and hold off until every outstanding result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (board.due_count() != 0);
	endtask

	// Mostly keys already in the list for index-of; a small pool to make duplicates.
	function automatic logic [31:0] pick_value(bit as_key);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (as_key && board.occupancy() != 0 && r < 7)
			return board.value_at($urandom_range(0, board.occupancy() - 1));
		if (r < 3)
			return $urandom_range(0, 7);
		if (r == 3)
			return '1;
		if (r == 4)
			return '0;
		return $urandom;
	endfunction

	task automatic run_phase(int unsigned ins_w, int unsigned era_w, int unsigned items,
			bit force_quiet);
		int unsigned r;
		int unsigned size;
		action_t     act;
		logic [6:0]  pos;
		send_quiet = force_quiet || ($urandom_range(0, 2) == 0);
		take_quiet = force_quiet || ($urandom_range(0, 2) == 0);
		repeat (items) begin
			size = board.occupancy();
			r = $urandom_range(0, 99);
			if (r < ins_w)
				act = ACT_INSERT;
			else if (r < ins_w + era_w)
				act = ACT_ERASE;
			else if (r[0])
				act = ACT_GET;
			else
				act = ACT_FIND;
			// legal positions mostly, some just past the end, some anywhere in the field
			r = $urandom_range(0, 99);
			if (r < 8)
				pos = 7'($urandom_range(0, 127));
			else if (r < 14 || (act != ACT_INSERT && size == 0))
				pos = 7'((act == ACT_INSERT) ? size + 1 : size);
			else
				pos = 7'($urandom_range(0, (act == ACT_INSERT) ? size : size - 1));
			send_word(act, pos, pick_value(act == ACT_FIND));
		end
		drain();
	endtask

	// Sink side: random stall before each word, then take it.
	initial begin
		int unsigned stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = idle_cycles(take_quiet);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_word(m_tuser, m_tdata);
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every action rejects or misses
		send_word(ACT_FIND, 7'd0, 32'h0);
		send_word(ACT_GET, 7'd0, 32'h0);
		send_word(ACT_ERASE, 7'd0, 32'h0);
		send_word(ACT_INSERT, 7'd1, 32'h0);
		// build: first element, new head, append at the end, middle, duplicate, then out of range
		send_word(ACT_INSERT, 7'd0, 32'h1);
		send_word(ACT_INSERT, 7'd0, 32'hFFFF_FFFF);
		send_word(ACT_INSERT, 7'd2, 32'h0);
		send_word(ACT_INSERT, 7'd1, 32'h5);
		send_word(ACT_INSERT, 7'd3, 32'h5);
		send_word(ACT_INSERT, 7'h7F, 32'hA5A5_5A5A);
		// reads at both ends and just past the end
		send_word(ACT_GET, 7'd0, 32'h0);
		send_word(ACT_GET, 7'd4, 32'h0);
		send_word(ACT_GET, 7'd5, 32'h0);
		// index-of: first of two matches, the tail, a miss
		send_word(ACT_FIND, 7'h7F, 32'h5);
		send_word(ACT_FIND, 7'd0, 32'h0);
		send_word(ACT_FIND, 7'd0, 32'h1234);
		// erase: position equal to the size, middle, head, tail, down to empty
		send_word(ACT_ERASE, 7'd5, 32'h0);
		send_word(ACT_ERASE, 7'd2, 32'h0);
		send_word(ACT_ERASE, 7'd0, 32'h0);
		send_word(ACT_ERASE, 7'd2, 32'h0);
		send_word(ACT_GET, 7'd1, 32'h0);
		send_word(ACT_ERASE, 7'd0, 32'h0);
		send_word(ACT_ERASE, 7'd0, 32'h0);
		send_word(ACT_FIND, 7'd0, 32'h5);
		drain();

		// grow to full and back to empty twice, with mixed traffic between
		run_phase(40, 30, 130, 1'b0);
		run_phase(85, 5, 150, 1'b1);
		run_phase(5, 85, 150, 1'b0);
		run_phase(35, 35, 130, 1'b0);
		run_phase(80, 10, 130, 1'b0);
		run_phase(10, 80, 110, 1'b0);

		repeat (TAIL_WAIT) @(posedge clk);
		if (board.errors == 0 && board.due_count() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
